@@ sv/mfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants
// Sizes, payload structs and codes for the monochrome framebuffer scan-out.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int MAX_WIDTH    = 128;
  localparam int MAX_HEIGHT   = 64;
  localparam int WORD_BITS    = 32;
  localparam int BLOCK_WIDTH  = 16;
  localparam int BLOCK_HEIGHT = 8;
  localparam int COLOUR_BITS  = 16;

  localparam int ROW_WORDS   = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int STORE_DEPTH = ROW_WORDS * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);

  localparam int XMAX_W = $clog2(MAX_WIDTH / BLOCK_WIDTH + 1);
  localparam int YMAX_W = $clog2(MAX_HEIGHT / BLOCK_HEIGHT + 1);
  localparam int BC_W   = $clog2(MAX_WIDTH / BLOCK_WIDTH);
  localparam int BR_W   = $clog2(MAX_HEIGHT / BLOCK_HEIGHT);
  localparam int CIB_W  = $clog2(BLOCK_WIDTH);
  localparam int RIB_W  = $clog2(BLOCK_HEIGHT);
  localparam int SCALE_W = 4;
  localparam int ORIGIN_W = 10;
  localparam int RECT_W   = 12;
  localparam int UW_W     = 8;
  localparam int UH_W     = 7;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USED_WIDTH  = 4'd0,
    REG_USED_HEIGHT = 4'd1,
    REG_SCALE_H     = 4'd2,
    REG_SCALE_V     = 4'd3,
    REG_ORIGIN_X    = 4'd4,
    REG_ORIGIN_Y    = 4'd5,
    REG_INK         = 4'd6,
    REG_PAPER       = 4'd7
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_colour;
  } mfs_in_t;

  typedef struct packed {
    logic                   read_bit;
    logic                   out_valid;
    logic [COLOUR_BITS-1:0] out_colour;
    logic [RECT_W-1:0]      rect_x;
    logic [RECT_W-1:0]      rect_y;
    logic                   block_first;
    logic                   block_last;
    logic                   frame_last;
  } mfs_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } mfs_cfg_t;

endpackage

@@ sv/mfs_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_intf: valid/ready channels
// Item, result and configuration channels of the framebuffer scan-out.
// ----------------------------------------------------------------------------
interface mfs_in_if;
  import mfs_pkg::*;
  logic    valid;
  logic    ready;
  mfs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfs_out_if;
  import mfs_pkg::*;
  logic     valid;
  logic     ready;
  mfs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfs_cfg_if;
  import mfs_pkg::*;
  logic     valid;
  logic     ready;
  mfs_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/mono_framebuffer_scaled_scanout.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_scaled_scanout: 1 bpp framebuffer with scaled scan-out
// Set/get of single pixels, whole-frame clear and tiled, integer-scaled pixel readout.
// ----------------------------------------------------------------------------
// The word is read from the single-port store in the accept cycle (synchronous
// read; none for a clear), then, once the result slot is free, modified, written
// back by a set and loaded into the result register. The next item is accepted
// once that result is loaded, even while it still waits to be taken. Clear acts
// at once through per-word valid flags: no clearing pass runs after reset or clear.
// Configuration writes are always ready and must only be issued while idle.
module mono_framebuffer_scaled_scanout (
  input  logic  clk_i,
  input  logic  rst_ni,
  mfs_cfg_if.sink   cfg_i,
  mfs_in_if.sink    in_i,
  mfs_out_if.source out_o
);
  import mfs_pkg::*;

  typedef struct packed {
    op_e              op;
    logic             hit;
    logic             colour;
    logic [BIT_W-1:0] bit_sel;
    logic             scan_ok;
    logic             first;
    logic             last;
    logic             flast;
    logic [RECT_W-1:0] rect_x;
    logic [RECT_W-1:0] rect_y;
  } pend_t;

  // configuration
  logic [UW_W-1:0]        used_width_q;
  logic [UH_W-1:0]        used_height_q;
  logic [SCALE_W-1:0]     scale_h_q, scale_v_q;
  logic [ORIGIN_W-1:0]    origin_x_q, origin_y_q;
  logic [COLOUR_BITS-1:0] ink_q, paper_q;

  // scan position
  logic [BC_W-1:0]    bc_q, bc_d;
  logic [BR_W-1:0]    br_q, br_d;
  logic [RIB_W-1:0]   rib_q, rib_d;
  logic [SCALE_W-1:0] rr_q, rr_d;
  logic [CIB_W-1:0]   cib_q, cib_d;
  logic [SCALE_W-1:0] cr_q, cr_d;

  // store
  logic [WORD_BITS-1:0]   mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [WORD_BITS-1:0]   rd_data_q;
  logic [ADDR_W-1:0]      addr_q, rd_addr;
  logic                   rd_en, wr_en, clr;
  logic [WORD_BITS-1:0]   wr_data, word;

  state_e   state_q, state_d;
  pend_t    pend_q, pend_d;
  logic     out_valid_q;
  mfs_out_t out_data_q, res;
  logic     in_fire, exec_done;

  // scan helpers
  logic [XMAX_W-1:0] xmax;
  logic [YMAX_W-1:0] ymax;
  logic              scan_ok, restart, pix_hit;
  logic [BC_W-1:0]   bc;
  logic [BR_W-1:0]   br;
  logic [RIB_W-1:0]  rib;
  logic [SCALE_W-1:0] rr, cr;
  logic [CIB_W-1:0]  cib;
  logic [X_W-1:0]    sx_pix, gx;
  logic [Y_W-1:0]    sy_pix, gy;
  logic              first, last;
  op_e               in_op;

  assign cfg_i.ready = 1'b1;
  assign in_op       = op_e'(in_i.data.op);
  assign in_fire     = in_i.valid && in_i.ready;
  assign exec_done   = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_width_q  <= UW_W'(MAX_WIDTH);
      used_height_q <= UH_W'(MAX_HEIGHT);
      scale_h_q     <= SCALE_W'(1);
      scale_v_q     <= SCALE_W'(1);
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      ink_q         <= '0;
      paper_q       <= '1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_USED_WIDTH: begin
          if (cfg_i.data.wdata[UW_W-1:0] <= UW_W'(MAX_WIDTH)) begin
            used_width_q <= cfg_i.data.wdata[UW_W-1:0];
          end
        end
        REG_USED_HEIGHT: begin
          if (cfg_i.data.wdata[UH_W-1:0] <= UH_W'(MAX_HEIGHT)) begin
            used_height_q <= cfg_i.data.wdata[UH_W-1:0];
          end
        end
        REG_SCALE_H:  scale_h_q  <= cfg_i.data.wdata[SCALE_W-1:0];
        REG_SCALE_V:  scale_v_q  <= cfg_i.data.wdata[SCALE_W-1:0];
        REG_ORIGIN_X: origin_x_q <= cfg_i.data.wdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y: origin_y_q <= cfg_i.data.wdata[ORIGIN_W-1:0];
        REG_INK:      ink_q      <= cfg_i.data.wdata[COLOUR_BITS-1:0];
        REG_PAPER:    paper_q    <= cfg_i.data.wdata[COLOUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // scan position and next position
  assign xmax    = XMAX_W'(used_width_q / BLOCK_WIDTH);
  assign ymax    = YMAX_W'(used_height_q / BLOCK_HEIGHT);
  assign scan_ok = (xmax != '0) && (ymax != '0) && (scale_h_q != '0) && (scale_v_q != '0);
  assign restart = (bc_q >= xmax) || (br_q >= ymax) || (int'(rib_q) >= BLOCK_HEIGHT) ||
                   (rr_q >= scale_v_q) || (int'(cib_q) >= BLOCK_WIDTH) ||
                   (cr_q >= scale_h_q);
  assign bc  = restart ? '0 : bc_q;
  assign br  = restart ? '0 : br_q;
  assign rib = restart ? '0 : rib_q;
  assign rr  = restart ? '0 : rr_q;
  assign cib = restart ? '0 : cib_q;
  assign cr  = restart ? '0 : cr_q;

  assign sx_pix = X_W'(int'(bc) * BLOCK_WIDTH + int'(cib));
  assign sy_pix = Y_W'(int'(br) * BLOCK_HEIGHT + int'(rib));
  assign first  = (rib == '0) && (rr == '0) && (cib == '0) && (cr == '0);
  assign last   = (int'(rib) == BLOCK_HEIGHT - 1) && (rr == scale_v_q - SCALE_W'(1)) &&
                  (int'(cib) == BLOCK_WIDTH - 1) && (cr == scale_h_q - SCALE_W'(1));

  always_comb begin
    bc_d  = bc;
    br_d  = br;
    rib_d = rib;
    rr_d  = rr;
    cib_d = cib;
    cr_d  = cr;
    if (int'(cr) + 1 >= int'(scale_h_q)) begin
      cr_d = '0;
      if (int'(cib) + 1 >= BLOCK_WIDTH) begin
        cib_d = '0;
        if (int'(rr) + 1 >= int'(scale_v_q)) begin
          rr_d = '0;
          if (int'(rib) + 1 >= BLOCK_HEIGHT) begin
            rib_d = '0;
            if (int'(bc) + 1 >= int'(xmax)) begin
              bc_d = '0;
              if (int'(br) + 1 >= int'(ymax)) begin
                br_d = '0;
              end else begin
                br_d = br + BR_W'(1);
              end
            end else begin
              bc_d = bc + BC_W'(1);
            end
          end else begin
            rib_d = rib + RIB_W'(1);
          end
        end else begin
          rr_d = rr + SCALE_W'(1);
        end
      end else begin
        cib_d = cib + CIB_W'(1);
      end
    end else begin
      cr_d = cr + SCALE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q  <= '0;
      br_q  <= '0;
      rib_q <= '0;
      rr_q  <= '0;
      cib_q <= '0;
      cr_q  <= '0;
    end else if (in_fire && (in_op == OP_SCAN) && scan_ok) begin
      bc_q  <= bc_d;
      br_q  <= br_d;
      rib_q <= rib_d;
      rr_q  <= rr_d;
      cib_q <= cib_d;
      cr_q  <= cr_d;
    end
  end

  // read address and pending item
  assign pix_hit = (in_i.data.pixel_x < used_width_q) && (in_i.data.pixel_y < used_height_q);
  assign gx      = in_i.data.pixel_x[X_W-1:0];
  assign gy      = in_i.data.pixel_y[Y_W-1:0];

  always_comb begin
    pend_d         = '0;
    pend_d.op      = in_op;
    pend_d.colour  = in_i.data.pixel_colour;
    if (in_op == OP_SCAN) begin
      rd_addr        = ADDR_W'(int'(sy_pix) * ROW_WORDS + (int'(sx_pix) >> BIT_W));
      pend_d.bit_sel = sx_pix[BIT_W-1:0];
      pend_d.scan_ok = scan_ok;
      pend_d.first   = first;
      pend_d.last    = last;
      pend_d.flast   = last && (int'(bc) == int'(xmax) - 1) && (int'(br) == int'(ymax) - 1);
      pend_d.rect_x  = RECT_W'(int'(origin_x_q) + int'(bc) * BLOCK_WIDTH * int'(scale_h_q));
      pend_d.rect_y  = RECT_W'(int'(origin_y_q) + int'(br) * BLOCK_HEIGHT * int'(scale_v_q));
    end else begin
      rd_addr        = ADDR_W'(int'(gy) * ROW_WORDS + (int'(gx) >> BIT_W));
      pend_d.bit_sel = gx[BIT_W-1:0];
      pend_d.hit     = pix_hit;
    end
  end

  assign rd_en = in_fire && (in_op != OP_CLEAR);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_q <= pend_d;
      addr_q <= rd_addr;
    end
  end

  // single-port store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // modify, write back, build result
  assign word = vld_q[addr_q] ? rd_data_q : '0;

  always_comb begin
    res     = '0;
    wr_en   = 1'b0;
    clr     = 1'b0;
    wr_data = word;
    unique case (pend_q.op)
      OP_SET: begin
        wr_en = exec_done && pend_q.hit;
        wr_data[pend_q.bit_sel] = !pend_q.colour;
      end
      OP_GET: begin
        res.read_bit = pend_q.hit && word[pend_q.bit_sel];
      end
      OP_CLEAR: begin
        clr = exec_done;
      end
      OP_SCAN: begin
        if (pend_q.scan_ok) begin
          res.out_valid   = 1'b1;
          res.out_colour  = word[pend_q.bit_sel] ? ink_q : paper_q;
          res.rect_x      = pend_q.rect_x;
          res.rect_y      = pend_q.rect_y;
          res.block_first = pend_q.first;
          res.block_last  = pend_q.last;
          res.frame_last  = pend_q.flast;
        end
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      out_data_q <= res;
    end
  end

  // checks
  a_fire_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter execute");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && out_valid_q && !out_o.ready |=> (state_q == ST_EXEC))
    else $error("execute left while result slot occupied");

  a_flast_blast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.frame_last |-> out_data_q.block_last)
    else $error("frame end without block end");

  a_scan_nobit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.out_valid |-> !out_data_q.read_bit)
    else $error("scan result carries a read bit");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_done |=> out_valid_q)
    else $error("finished item left no result");

endmodule
